// File: rtl/linear_probe_hash_table_macros.svh
// Assertion macros used by the top level of the hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/lpht_pkg.sv
// Package with types and constants, including the hash multiplier, for the hash table.
package lpht_pkg;
  localparam int TableDepth  = 1024;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int CntW        = IdxW + 1;
  localparam int PayloadBits = 32;
  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_ZERO = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_CLEAR, S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;    // latch the word and start hash multiply
    logic mod_start;  // load remainder unit
    logic mod_step;   // one restoring step
    logic load_slot;  // slot <= remainder
    logic rd;         // issue memory read at slot
    logic wr;         // write key and payload at slot
    logic adv;        // next slot, one more probe
    logic clr_start;  // begin clearing sweep
    logic clr_wr;     // clear one slot and advance
    logic hit;        // record lookup hit
    logic set_status;
    status_t status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    mode_t mode;
    logic  key_zero;
    logic  full;       // insert would leave no empty slot
    logic  empty_tbl;
    logic  mod_done;
    logic  slot_empty;
    logic  slot_match;
    logic  probes_done; // all slots in use visited
    logic  clr_done;
  } stat_t;
endpackage

// File: rtl/lpht_ctrl.sv
// Controller state machine of the hash table.
module lpht_ctrl import lpht_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  logic   out_busy,
  input  stat_t  st,
  output cmd_t   cmd,
  output state_t state
);
  state_t state_r, state_nxt;
  assign state = state_r;

  // State register; reset starts the sweep that empties every slot.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status = ST_OK;
    case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (st.mode == MODE_CLEAR) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLEAR;
        end else if (st.mode == MODE_NOP) begin
          cmd.set_status = 1'b1;
          state_nxt = S_DONE;
        end else if (st.key_zero) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_ZERO;
          state_nxt = S_DONE;
        end else if (st.mode == MODE_INSERT && st.full) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_FULL;
          state_nxt = S_DONE;
        end else if (st.mode == MODE_LOOKUP && st.empty_tbl) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_MISS;
          state_nxt = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (st.mod_done) begin
          cmd.load_slot = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.mode == MODE_INSERT) begin
          if (st.slot_empty) begin
            cmd.wr = 1'b1;
            cmd.set_status = 1'b1;
            state_nxt = S_DONE;
          end else if (st.probes_done) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cmd.adv = 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          if (st.slot_match) begin
            cmd.hit = 1'b1;
            cmd.set_status = 1'b1;
            state_nxt = S_DONE;
          end else if (st.slot_empty || st.probes_done) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_MISS;
            state_nxt = S_DONE;
          end else begin
            cmd.adv = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) begin
          cmd.set_status = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: rtl/lpht_dpath.sv
// Datapath of the hash table: hash, remainder unit, slot stores, counters.
module lpht_dpath import lpht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [1:0]       in_mode,
  input  logic [31:0]      in_key,
  input  logic [31:0]      in_payload,
  input  logic [10:0]      cfg_buckets,
  output stat_t            st,
  output status_t          res_status,
  output logic             res_found,
  output logic [31:0]      res_payload
);
  // Clamp slots in use to 2..TableDepth.
  logic [CntW-1:0] buckets;
  always_comb begin
    if (cfg_buckets < 11'd2)                             buckets = CntW'(2);
    else if ({21'd0, cfg_buckets} > 32'(TableDepth))     buckets = CntW'(TableDepth);
    else                                                  buckets = CntW'(cfg_buckets);
  end

  mode_t             mode_r;
  logic [31:0]       key_r, hash_r;
  logic [PayloadBits-1:0] pay_r;
  logic [CntW-1:0]   ecount_r;
  logic [CntW-1:0]   rem_r;
  logic [5:0]        mstep_r;
  logic [IdxW-1:0]   slot_r;
  logic [CntW-1:0]   nprobe_r;
  logic [IdxW:0]     clr_r;
  logic [31:0]       rkey_r;
  logic [PayloadBits-1:0] rpay_r;
  status_t           stat_r;
  logic              found_r;
  logic [31:0]       pout_r;

  logic [31:0]         key_mem [TableDepth];
  logic [PayloadBits-1:0] pay_mem [TableDepth];

  // Restoring remainder: shift one dividend bit in per cycle.
  logic [CntW:0] rem_sh;
  assign rem_sh = {rem_r, hash_r[31]};

  // Word capture, hash multiply, remainder and probe counters.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      key_r  <= in_key;
      pay_r  <= in_payload;
      hash_r <= in_key * HashMult;
    end
    if (cmd.mod_start) begin
      rem_r   <= '0;
      mstep_r <= '0;
    end else if (cmd.mod_step) begin
      rem_r   <= (rem_sh >= {1'b0, buckets}) ? CntW'(rem_sh - {1'b0, buckets})
                                             : CntW'(rem_sh);
      hash_r  <= {hash_r[30:0], 1'b0};
      mstep_r <= mstep_r + 6'd1;
    end
    if (cmd.load_slot) begin
      slot_r   <= IdxW'(rem_r);
      nprobe_r <= CntW'(1);
    end else if (cmd.adv) begin
      slot_r   <= ({1'b0, slot_r} + 1'b1 == buckets) ? '0 : slot_r + 1'b1;
      nprobe_r <= nprobe_r + 1'b1;
    end
  end

  // Slot stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      key_mem[slot_r] <= key_r;
      pay_mem[slot_r] <= pay_r;
    end else if (cmd.clr_wr) begin
      key_mem[clr_r[IdxW-1:0]] <= '0;
    end
    if (cmd.rd) begin
      rkey_r <= key_mem[slot_r];
      rpay_r <= pay_mem[slot_r];
    end
  end

  // Entry count and sweep counter; the sweep after reset starts at slot zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= '0;
      clr_r    <= '0;
    end else begin
      if (cmd.clr_start) ecount_r <= '0;
      else if (cmd.wr)   ecount_r <= ecount_r + 1'b1;
      if (cmd.clr_start)   clr_r <= '0;
      else if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      stat_r  <= cmd.status;
      found_r <= cmd.hit;
      pout_r  <= cmd.hit ? 32'(rpay_r) : '0;
    end
  end

  assign st.mode        = mode_r;
  assign st.key_zero    = (key_r == '0);
  assign st.full        = ({1'b0, ecount_r} + 1'b1) >= {1'b0, buckets};
  assign st.empty_tbl   = (ecount_r == '0);
  assign st.mod_done    = (mstep_r == 6'd32);
  assign st.slot_empty  = (rkey_r == '0);
  assign st.slot_match  = (rkey_r == key_r);
  assign st.probes_done = (nprobe_r >= buckets);
  assign st.clr_done    = (clr_r == (IdxW+1)'(TableDepth - 1));
  assign res_status     = stat_r;
  assign res_found      = found_r;
  assign res_payload    = pout_r;
endmodule

// File: rtl/linear_probe_hash_table.sv
// Top level of the linear-probing hash table.
//  channel | direction | fields
//  in_     | slave     | tuser: mode; tdata: key, payload_in
//  out_    | master    | tuser: status, found; tdata: payload_out
//  cfg_    | write     | buckets_in_use
// An insert or lookup runs the hash, the 32-step remainder unit, then one read
// and one check per probe through the one read port of the slot store.
// Clear sweeps all 1024 slots, one per cycle. Reset clears control state
// and runs the same sweep before the first word is taken.
// A held result stalls the block; a new word is taken once it has left.
`include "linear_probe_hash_table_macros.svh"
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic [63:0] in_tdata,   // key[31:0], payload_in[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status[1:0], found[2]
  output logic [31:0] out_tdata,  // payload_out[31:0]
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  cmd_t    cmd;
  stat_t   st;
  state_t  state;
  status_t res_status;
  logic    res_found;
  logic [31:0] res_payload;
  logic [10:0] buckets_r;
  logic    out_valid_r;
  logic    in_fire;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n)      buckets_r <= 11'd1024;
    else if (cfg_we) buckets_r <= cfg_wdata;
  end

  assign in_tready = (state == S_IDLE) && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  // Output word valid.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state == S_DONE && !out_valid_r) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  lpht_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r), .st, .cmd, .state
  );

  lpht_dpath u_dpath (
    .clk, .rst_n, .cmd,
    .in_mode(in_tuser), .in_key(in_tdata[31:0]), .in_payload(in_tdata[63:32]),
    .cfg_buckets(buckets_r), .st, .res_status, .res_found, .res_payload
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_found, res_status};
  assign out_tdata  = res_payload;

  `LPHT_ASSERT_IMP(a_no_accept_busy, in_fire, state == S_IDLE, "word accepted while busy")
  `LPHT_ASSERT_IMP(a_found_ok, out_tvalid && out_tuser[2], out_tuser[1:0] == ST_OK, "hit not ok")
  `LPHT_ASSERT_NXT(a_write_done, cmd.wr, state == S_DONE, "insert did not finish")
endmodule

// File: test/testbench.sv
// Self-checking testbench for the linear-probing hash table.
`timescale 1ns / 1ps
module testbench import lpht_pkg::*; ();

  localparam int Depth = 1024;
  localparam longint CycleLimit = 3000000;
  localparam int SettleCycles = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // mode[1:0]
  logic [63:0] in_tdata;   // key[31:0], payload_in[63:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // status[1:0], found[2]
  logic [31:0] out_tdata;  // payload_out[31:0]
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] payload;
  } answer_t;

  // Shadow copy of the table.
  logic [31:0] shadow_keys[Depth];
  logic [31:0] shadow_pay[Depth];
  int unsigned shadow_count;
  int unsigned shadow_buckets;

  answer_t answer_queue[$];
  int unsigned mismatches;
  bit          failed;
  bit          rx_hold;
  longint      cycles;
  logic [31:0] used_keys[$];

  linear_probe_hash_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the answer of one operation and update the shadow table.
  function automatic answer_t table_answer(mode_t mode, logic [31:0] key, logic [31:0] pay);
    answer_t a;
    int unsigned b;
    int unsigned s;
    logic [31:0] h;
    a = '{ST_OK, 1'b0, 32'd0};
    b = shadow_buckets < 2 ? 2 : (shadow_buckets > Depth ? Depth : shadow_buckets);
    h = key * HashMult;
    s = h % b;
    if (mode == MODE_CLEAR) begin
      foreach (shadow_keys[i]) shadow_keys[i] = '0;
      shadow_count = 0;
    end else if (mode == MODE_INSERT || mode == MODE_LOOKUP) begin
      if (key == 0) begin
        a.status = ST_ZERO;
      end else if (mode == MODE_INSERT) begin
        a.status = ST_FULL;
        if (shadow_count + 1 < b) begin
          for (int n = 0; n < b; n++) begin
            if (shadow_keys[s] == 0) begin
              shadow_keys[s] = key;
              shadow_pay[s] = pay;
              shadow_count = (shadow_count + 1) & 11'h7ff;
              a.status = ST_OK;
              break;
            end
            s = (s + 1 == b) ? 0 : s + 1;
          end
        end
      end else begin
        a.status = ST_MISS;
        if (shadow_count != 0) begin
          for (int n = 0; n < b; n++) begin
            if (shadow_keys[s] == key) begin
              a = '{ST_OK, 1'b1, shadow_pay[s]};
              break;
            end
            if (shadow_keys[s] == 0) break;
            s = (s + 1 == b) ? 0 : s + 1;
          end
        end
      end
    end
    return a;
  endfunction

  // Send one word after a random gap; driven at the falling edge.
  task automatic send_op(mode_t mode, logic [31:0] key, logic [31:0] pay, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = {pay, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    answer_queue.push_back(table_answer(mode, key, pay));
    if (mode == MODE_INSERT && key != 0) used_keys.push_back(key);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (answer_queue.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_buckets(logic [10:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_buckets = value;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && used_keys.size() != 0) return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r == 6) return $urandom_range(1, 8);
    if (r == 7) return 32'hffff_fff0 | $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic random_ops(int count, int insert_pct);
    mode_t m;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) m = MODE_INSERT;
      else if (r < 96) m = MODE_LOOKUP;
      else if (r < 98) m = MODE_NOP;
      else m = MODE_CLEAR;
      send_op(m, ($urandom_range(0, 40) == 0) ? 32'd0 : pick_key(), $urandom);
    end
  endtask

  // Directed corner cases, first on the full-size table, then on small ones.
  task automatic test_directed();
    send_op(MODE_CLEAR, 32'hdead_beef, 32'd0);
    send_op(MODE_LOOKUP, 32'd5, 32'd0);
    send_op(MODE_INSERT, 32'd0, 32'hffff_ffff);
    send_op(MODE_LOOKUP, 32'd0, 32'd0);
    send_op(MODE_NOP, 32'hffff_ffff, 32'hffff_ffff);
    send_op(MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    send_op(MODE_INSERT, 32'd1, 32'd0);
    send_op(MODE_INSERT, 32'hffff_ffff, 32'h1234_5678);
    send_op(MODE_LOOKUP, 32'hffff_ffff, 32'd0);
    send_op(MODE_LOOKUP, 32'd1, 32'd0);
    send_op(MODE_LOOKUP, 32'd2, 32'd0);
    write_buckets(11'd0);
    send_op(MODE_CLEAR, 32'd0, 32'd0);
    send_op(MODE_INSERT, 32'd7, 32'haaaa_5555);
    send_op(MODE_INSERT, 32'd9, 32'h5555_aaaa);
    send_op(MODE_LOOKUP, 32'd7, 32'd0);
    write_buckets(11'd4);
    for (int k = 1; k <= 4; k++) send_op(MODE_INSERT, k, k * 3);
    send_op(MODE_LOOKUP, 32'd3, 32'd0);
    // Shrink while filled so probes wrap past the end of the smaller table.
    write_buckets(11'd2);
    send_op(MODE_INSERT, 32'd11, 32'd1);
    send_op(MODE_LOOKUP, 32'd99, 32'd0);
    send_op(MODE_LOOKUP, 32'd1, 32'd0);
  endtask

  // Run mostly valid traffic on a clamped full-size table, then fill small tables past their limit.
  task automatic test_small_tables();
    write_buckets(11'd2047);
    send_op(MODE_CLEAR, 32'd0, 32'd0);
    random_ops(150, 50);
    write_buckets(11'd1);
    random_ops(40, 50);
    write_buckets(11'd13);
    send_op(MODE_CLEAR, 32'd0, 32'd0);
    random_ops(250, 45);
  endtask

  // Receiver stalls long while the sender keeps offering words.
  task automatic test_backpressure();
    write_buckets(11'd64);
    send_op(MODE_CLEAR, 32'd0, 32'd0);
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_op(MODE_INSERT, pick_key(), $urandom, 1);
    join
    wait_drained();
  endtask

  task automatic test_large_table();
    write_buckets(11'd1024);
    send_op(MODE_CLEAR, 32'd0, 32'd0);
    random_ops(230, 40);
    write_buckets(11'd200);
    random_ops(330, 35);
  endtask

  // Result checker.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = status_t'(out_tuser[1:0]);
      got.found   = out_tuser[2];
      got.payload = out_tdata;
      if (answer_queue.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h %h", out_tuser, out_tdata);
      end else begin
        want = answer_queue.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d found %0d/%0d payload %h/%h (expected/actual)",
                     want.status, got.status, want.found, got.found, want.payload, got.payload);
        end
      end
    end
  end

  // Receiver ready with random stalls.
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (out_tready && out_tvalid) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rx_hold = 1'b0;
    failed = 1'b0;
    mismatches = 0;
    shadow_count = 0;
    shadow_buckets = 1024;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    foreach (shadow_pay[i]) shadow_pay[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_small_tables();
    test_backpressure();
    test_large_table();
    wait_drained();
    if (!failed && answer_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
